// ----- hw/rtl/qte_pkg.sv -----
// Shared types, constants and arctangent table for the quaternion to Euler converter.
`default_nettype none

package qte_pkg;

    localparam int SUM_W      = 35;
    localparam int CW         = 37;
    localparam int ZW         = 34;
    localparam int ISQ_W      = 58;
    localparam int ISQ_STEPS  = 29;
    localparam int NORM_STEPS = 5;
    localparam int ANG_W      = 16;

    localparam logic signed [SUM_W-1:0] ONE_Q28     = SUM_W'(64'sd268435456);
    localparam logic signed [ZW-1:0]    PI_Q30      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0]    HALF_PI_Q30 = ZW'(64'sd1686629713);
    localparam logic [28:0]             DEG_SCALE   = 29'd480631834;

    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic                    force_on;
        logic                    force_neg;
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ZW-1:0]    z;
    } cordic_t;

    typedef struct packed {
        logic              valid;
        logic [ISQ_W-1:0]  n;
        logic [ISQ_W-1:0]  res;
    } sqrt_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sp;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic                    hi;
        logic                    lo;
    } side_t;

    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            24: v = 32'd63;
            25: v = 32'd31;
            26: v = 32'd15;
            27: v = 32'd8;
            28: v = 32'd4;
            29: v = 32'd2;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// Top level: quaternion to roll, pitch and yaw (Z-Y-X) converter pipeline.
//
// Channel  Dir  Handshake               Word
// s_axis   in   tvalid/tready           quat_w, quat_x, quat_y, quat_z
// m_axis   out  tvalid/tready           roll, pitch, yaw; tuser pitch_clamped
// cfg      in   cfg_valid/cfg_ready     angle_in_degrees
//
// One word enters per cycle while the output is not stalled; the pipeline runs through the
// 29-cell square-root chain and the CORDIC cell row of each lane.
// Reset clears every valid bit and selects radians.
// A stalled output word freezes the whole pipeline until it is taken.
`default_nettype none

module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int DATA_WIDTH    = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, zero fill
    input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // roll, pitch, yaw
    output logic [47:0]              m_axis_tdata,
    // pitch_clamped
    output logic [0:0]               m_axis_tuser,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [0:0]          cfg_data
);

    localparam int SIDE_DEPTH = ISQ_STEPS + 2;

    logic adv;
    logic mode_reg;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data[0];
        end
    end

    logic signed [15:0] q_in [4];

    for (genvar k = 0; k < 4; k++)
    begin : g_conv
        logic [DATA_WIDTH-1:0] raw;
        assign raw = s_axis_tdata[k*DATA_WIDTH +: DATA_WIDTH];
        if (DATA_WIDTH >= 16)
        begin : g_down
            assign q_in[k] = $signed(raw[DATA_WIDTH-1 -: 16]);
        end
        else
        begin : g_up
            assign q_in[k] = $signed({raw, {(16-DATA_WIDTH){1'b0}}});
        end
    end

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [31:0] wz_reg, xy_reg, zz_reg;
    side_t s2_reg;
    side_t s2_next;
    logic [56:0] sq_reg;
    sqrt_t sq_in_reg;
    sqrt_t sq_in_next;
    logic signed [57:0] sq_next;
    side_t side_reg [0:SIDE_DEPTH-1];

    always_comb
    begin
        s2_next.sr = (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
        s2_next.cr = ONE_Q28 - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
        s2_next.sp = (SUM_W'(wy_reg) - SUM_W'(zx_reg)) <<< 1;
        s2_next.sy = (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
        s2_next.cy = ONE_Q28 - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
        s2_next.hi = s2_next.sp >= ONE_Q28;
        s2_next.lo = s2_next.sp <= -ONE_Q28;
        sq_next    = $signed(s2_reg.sp[28:0]) * $signed(s2_reg.sp[28:0]);
        sq_in_next.valid = v3_reg;
        sq_in_next.n     = (ISQ_W'(1) << 56) - ISQ_W'(sq_reg);
        sq_in_next.res   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            sq_in_reg <= '0;
        end
        else if (adv)
        begin
            v0_reg    <= s_axis_tvalid;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            sq_in_reg <= sq_in_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg  <= q_in[0];
            x_reg  <= q_in[1];
            y_reg  <= q_in[2];
            z_reg  <= q_in[3];
            wx_reg <= w_reg * x_reg;
            yz_reg <= y_reg * z_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            wy_reg <= w_reg * y_reg;
            zx_reg <= z_reg * x_reg;
            wz_reg <= w_reg * z_reg;
            xy_reg <= x_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            s2_reg <= s2_next;
            sq_reg <= sq_next[56:0];
            side_reg[0] <= s2_reg;
            for (int i = 1; i < SIDE_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    sqrt_t sq_chain [0:ISQ_STEPS];

    assign sq_chain[0] = sq_in_reg;

    for (genvar k = 0; k < ISQ_STEPS; k++)
    begin : g_sqrt
        qte_sqrt_cell #(
            .STAGE (k)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .din   (sq_chain[k]),
            .dout  (sq_chain[k+1])
        );
    end

    side_t side_out;
    logic  lane_valid;
    logic signed [SUM_W-1:0] pitch_x;
    logic signed [ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;
    logic roll_valid;
    logic pitch_flag;

    assign side_out   = side_reg[SIDE_DEPTH-1];
    assign lane_valid = sq_chain[ISQ_STEPS].valid;
    assign pitch_x    = $signed({{(SUM_W-29){1'b0}}, sq_chain[ISQ_STEPS].res[28:0]});

    qte_atan2 #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .mode_deg  (mode_reg),
        .in_valid  (lane_valid),
        .y_in      (side_out.sr),
        .x_in      (side_out.cr),
        .force_in  (1'b0),
        .force_neg (1'b0),
        .out_valid (roll_valid),
        .angle     (roll_ang),
        .force_out ()
    );

    qte_atan2 #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .mode_deg  (mode_reg),
        .in_valid  (lane_valid),
        .y_in      (side_out.sp),
        .x_in      (pitch_x),
        .force_in  (side_out.hi || side_out.lo),
        .force_neg (side_out.lo),
        .out_valid (),
        .angle     (pitch_ang),
        .force_out (pitch_flag)
    );

    qte_atan2 #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .mode_deg  (mode_reg),
        .in_valid  (lane_valid),
        .y_in      (side_out.sy),
        .x_in      (side_out.cy),
        .force_in  (1'b0),
        .force_neg (1'b0),
        .out_valid (),
        .angle     (yaw_ang),
        .force_out ()
    );

    assign m_axis_tvalid = roll_valid;
    assign m_axis_tdata  = {yaw_ang, pitch_ang, roll_ang};
    assign m_axis_tuser  = pitch_flag;

endmodule

`default_nettype wire

// ----- hw/rtl/qte_sqrt_cell.sv -----
// One step of the pipelined integer square root: settles one result bit.
`default_nettype none

module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire sqrt_t din,
    output sqrt_t      dout
);

    localparam int SHIFT = 2 * (ISQ_STEPS - 1 - STAGE);
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << SHIFT;

    sqrt_t cell_reg;
    sqrt_t cell_next;
    logic [ISQ_W-1:0] trial;

    always_comb
    begin
        trial           = din.res + BIT;
        cell_next.valid = din.valid;
        if (din.n >= trial)
        begin
            cell_next.n   = din.n - trial;
            cell_next.res = (din.res >> 1) + BIT;
        end
        else
        begin
            cell_next.n   = din.n;
            cell_next.res = din.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (adv)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/qte_cordic_cell.sv -----
// One vectoring micro-rotation of the arctangent pipeline.
`default_nettype none

module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    adv,
    input  wire cordic_t din,
    output cordic_t      dout
);

    localparam logic signed [ZW-1:0] STEP_ANG =
        $signed({{(ZW-32){1'b0}}, atan_entry(STAGE)});

    cordic_t cell_reg;
    cordic_t cell_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    always_comb
    begin
        xs        = din.x >>> STAGE;
        ys        = din.y >>> STAGE;
        cell_next = din;
        if (din.y > 0)
        begin
            cell_next.x = din.x + ys;
            cell_next.y = din.y - xs;
            cell_next.z = din.z + STEP_ANG;
        end
        else
        begin
            cell_next.x = din.x - ys;
            cell_next.y = din.y + xs;
            cell_next.z = din.z - STEP_ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (adv)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/qte_atan2.sv -----
// Arctangent lane: quadrant fold, normalise, CORDIC cells and output scaling.
`default_nettype none

module qte_atan2
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    adv,
    input  wire logic                    mode_deg,
    input  wire logic                    in_valid,
    input  wire logic signed [SUM_W-1:0] y_in,
    input  wire logic signed [SUM_W-1:0] x_in,
    input  wire logic                    force_in,
    input  wire logic                    force_neg,
    output logic                         out_valid,
    output logic signed [ANG_W-1:0]      angle,
    output logic                         force_out
);

    cordic_t pre_next;
    cordic_t stg_reg [0:NORM_STEPS];
    cordic_t chain [0:CORDIC_STAGES];

    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;

    always_comb
    begin
        xe                 = CW'(x_in);
        ye                 = CW'(y_in);
        pre_next.valid     = in_valid;
        pre_next.zero      = (x_in == '0) && (y_in == '0);
        pre_next.force_on  = force_in;
        pre_next.force_neg = force_neg;
        pre_next.x         = xe;
        pre_next.y         = ye;
        pre_next.z         = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                pre_next.x = ye;
                pre_next.y = -xe;
                pre_next.z = HALF_PI_Q30;
            end
            else
            begin
                pre_next.x = -ye;
                pre_next.y = xe;
                pre_next.z = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg[0] <= '0;
        end
        else if (adv)
        begin
            stg_reg[0] <= pre_next;
        end
    end

    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        localparam int SH = 16 >> j;
        localparam logic signed [CW-1:0] LIM = CW'(longint'(1) <<< (32 - SH));
        cordic_t stg_next;

        always_comb
        begin
            stg_next = stg_reg[j];
            if ((stg_reg[j].x < LIM) && (stg_reg[j].y < LIM) && (stg_reg[j].y > -LIM))
            begin
                stg_next.x = stg_reg[j].x <<< SH;
                stg_next.y = stg_reg[j].y <<< SH;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_reg[j+1] <= '0;
            end
            else if (adv)
            begin
                stg_reg[j+1] <= stg_next;
            end
        end
    end

    assign chain[0] = stg_reg[NORM_STEPS];

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cell
        qte_cordic_cell #(
            .STAGE (k)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .din   (chain[k]),
            .dout  (chain[k+1])
        );
    end

    cordic_t last;
    logic signed [ZW-1:0] ang_sel;
    logic signed [ZW-1:0] ang_clip;
    logic [31:0]          mag_next;

    assign last = chain[CORDIC_STAGES];

    always_comb
    begin
        if (last.force_on)
        begin
            ang_sel = last.force_neg ? -HALF_PI_Q30 : HALF_PI_Q30;
        end
        else if (last.zero)
        begin
            ang_sel = '0;
        end
        else
        begin
            ang_sel = last.z;
        end
        if (ang_sel > PI_Q30)
        begin
            ang_clip = PI_Q30;
        end
        else if (ang_sel < -PI_Q30)
        begin
            ang_clip = -PI_Q30;
        end
        else
        begin
            ang_clip = ang_sel;
        end
        mag_next = ang_clip[ZW-1] ? 32'(-ang_clip) : 32'(ang_clip);
    end

    logic        va_reg;
    logic        na_reg;
    logic        fa_reg;
    logic [31:0] ma_reg;
    logic        vb_reg;
    logic        nb_reg;
    logic        fb_reg;
    logic [31:0] mb_reg;
    logic [60:0] pb_reg;
    logic        vc_reg;
    logic        fc_reg;
    logic signed [ANG_W-1:0] ac_reg;

    logic [32:0] rad_sum;
    logic [61:0] deg_sum;
    logic [ANG_W-1:0] rnd;
    logic signed [ANG_W-1:0] ac_next;

    always_comb
    begin
        rad_sum = {1'b0, mb_reg} + 33'(65536);
        deg_sum = {1'b0, pb_reg} + (62'(1) << 45);
        rnd     = mode_deg ? deg_sum[61:46] : rad_sum[32:17];
        ac_next = nb_reg ? -$signed(rnd) : $signed(rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= last.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            na_reg <= ang_clip[ZW-1];
            fa_reg <= last.force_on;
            ma_reg <= mag_next;
            nb_reg <= na_reg;
            fb_reg <= fa_reg;
            mb_reg <= ma_reg;
            pb_reg <= ma_reg * DEG_SCALE;
            fc_reg <= fb_reg;
            ac_reg <= ac_next;
        end
    end

    assign out_valid = vc_reg;
    assign angle     = ac_reg;
    assign force_out = fc_reg;

endmodule

`default_nettype wire

// ----- test/quaternion_to_euler_angles_tb.sv -----
// Self-checking testbench for the quaternion to Euler angle converter.
`default_nettype none

module quaternion_to_euler_angles_tb;
    import qte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      LATENCY   = 43 + 16;
    localparam int      N_STAGES  = 16;
    localparam longint  Q28_ONE   = 64'sd268435456;
    localparam longint  PI_A      = 64'sd3373259426;
    localparam longint  HALF_PI_A = 64'sd1686629713;
    localparam longint  DEG_MUL   = 64'sd480631834;

    localparam longint ARCTAN [0:15] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767
    };

    typedef struct packed {
        logic              clamped;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } euler_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data = '0;

    logic [63:0] quat_q[$];
    euler_t      angles_q[$];
    bit          deg_mode = 1'b0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          mismatches = 0;

    always #6 clk = ~clk;

    quaternion_to_euler_angles uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    function automatic longint cordic_angle(longint yv, longint xv);
        longint xa, ya, za, t, xs, ys;
        xa = xv;
        ya = yv;
        za = 0;
        if (xa == 0 && ya == 0)
            return 0;
        if (xa < 0) begin
            t = xa;
            if (ya >= 0)
            begin
                xa = ya; ya = -t; za = HALF_PI_A;
            end
            else
            begin
                xa = -ya; ya = t; za = -HALF_PI_A;
            end
        end
        while ((xa < 0 ? -xa : xa) < (64'sd1 << 31) && (ya < 0 ? -ya : ya) < (64'sd1 << 31))
        begin
            xa = xa * 2;
            ya = ya * 2;
        end
        for (int i = 0; i < N_STAGES; i++)
        begin
            xs = xa >>> i;
            ys = ya >>> i;
            if (ya > 0)
            begin
                xa = xa + ys; ya = ya - xs; za = za + ARCTAN[i];
            end
            else
            begin
                xa = xa - ys; ya = ya + xs; za = za - ARCTAN[i];
            end
        end
        return za;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [15:0] scale_angle(longint a, bit degrees);
        longint m, r;
        bit neg;
        if (a > PI_A) a = PI_A;
        if (a < -PI_A) a = -PI_A;
        neg = a < 0;
        m = neg ? -a : a;
        if (degrees)
            r = (m * DEG_MUL + (64'sd1 << 45)) >>> 46;
        else
            r = (m + (64'sd1 << 16)) >>> 17;
        if (neg) r = -r;
        return r[15:0];
    endfunction

    function automatic euler_t quat_to_euler(logic [63:0] q, bit degrees);
        longint w, x, y, z, sr, cr, sp, sy, cy, pa;
        euler_t e;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        sr = 2 * (w * x + y * z);
        cr = Q28_ONE - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        sy = 2 * (w * z + x * y);
        cy = Q28_ONE - 2 * (y * y + z * z);
        e.clamped = 1'b0;
        if (sp >= Q28_ONE)
        begin
            pa = HALF_PI_A; e.clamped = 1'b1;
        end
        else if (sp <= -Q28_ONE)
        begin
            pa = -HALF_PI_A; e.clamped = 1'b1;
        end
        else
            pa = cordic_angle(sp, int_sqrt((64'd1 << 56) - longint'(sp * sp)));
        e.roll  = scale_angle(cordic_angle(sr, cr), degrees);
        e.pitch = scale_angle(pa, degrees);
        e.yaw   = scale_angle(cordic_angle(sy, cy), degrees);
        return e;
    endfunction

    function automatic logic [63:0] quat(int w, int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0], w[15:0]};
    endfunction

    // drive input words from the pending queue, record predictions on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                angles_q.push_back(quat_to_euler(s_axis_tdata, deg_mode));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (quat_q.size() > 0 && (quiet || $urandom_range(99) >= 10))
                begin
                    s_axis_tdata  <= quat_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // check output words against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        euler_t want, got;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser[0], m_axis_tdata};
                if (angles_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", got);
                end
                else
                begin
                    want = angles_q.pop_front();
                    if (got.roll !== want.roll || got.pitch !== want.pitch ||
                        got.yaw !== want.yaw || got.clamped !== want.clamped)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected r %0d p %0d y %0d c %0d, got r %0d p %0d y %0d c %0d",
                                     want.roll, want.pitch, want.yaw, want.clamped,
                                     got.roll, got.pitch, got.yaw, got.clamped);
                    end
                end
            end
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= quiet || $urandom_range(99) >= 10;
        end
    end

    task automatic wait_idle();
        do @(negedge clk);
        while (quat_q.size() > 0 || angles_q.size() > 0 || s_axis_tvalid);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic set_mode(bit degrees);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= degrees;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        deg_mode = degrees;
    endtask

    task automatic add_random(int count);
        int w, x, y, z, k;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(9);
            w = $urandom; x = $urandom; y = $urandom; z = $urandom;
            if (k < 3)
            begin
                // near gimbal lock: w close to +/-y, small x and z
                y = (w[15] ? -1 : 1) * ((k == 0) ? 1 : -1) * ($signed(w[15:0]) +
                    $urandom_range(4) - 2);
                w = $urandom_range(10000, 13000) * (w[15] ? -1 : 1);
                y = (k == 1) ? -w + $urandom_range(20) - 10 : w + $urandom_range(20) - 10;
                x = $urandom_range(200) - 100;
                z = $urandom_range(200) - 100;
            end
            else if (k < 6)
            begin
                w = $signed(w[15:0]) >>> 1; x = $signed(x[15:0]) >>> 1;
                y = $signed(y[15:0]) >>> 1; z = $signed(z[15:0]) >>> 1;
            end
            quat_q.push_back(quat(w, x, y, z));
        end
    endtask

    initial
    begin
        bit modes [0:4] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        for (int ph = 0; ph < 5; ph++)
        begin
            set_mode(modes[ph]);
            quiet = (ph == 3);
            if (ph < 2)
            begin
                quat_q.push_back(quat(0, 0, 0, 0));
                quat_q.push_back(quat(16384, 0, 0, 0));
                quat_q.push_back(quat(32767, 32767, 32767, 32767));
                quat_q.push_back(quat(-32768, -32768, -32768, -32768));
                quat_q.push_back(quat(32767, -32768, 32767, -32768));
                quat_q.push_back(quat(-32768, 32767, -32768, 32767));
                quat_q.push_back(quat(0, 8192, 8192, 0));
                quat_q.push_back(quat(16384, 0, 8192, 0));
                quat_q.push_back(quat(16384, 0, -8192, 0));
                quat_q.push_back(quat(11586, 0, 11586, 0));
                quat_q.push_back(quat(11586, 0, -11586, 0));
                quat_q.push_back(quat(11585, 0, 11585, 0));
                quat_q.push_back(quat(0, 16384, 0, 0));
                quat_q.push_back(quat(0, 0, 16384, 0));
                quat_q.push_back(quat(0, 0, 0, 16384));
                quat_q.push_back(quat(-16384, 0, 0, 0));
            end
            if (ph == 2)
                hold_req = 1'b1;
            add_random(320);
            wait_idle();
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- quaternion_to_euler_angles.f -----
hw/rtl/qte_pkg.sv
hw/rtl/qte_sqrt_cell.sv
hw/rtl/qte_cordic_cell.sv
hw/rtl/qte_atan2.sv
hw/rtl/quaternion_to_euler_angles.sv
test/quaternion_to_euler_angles_tb.sv
